[rtl/fjot_pkg.sv]
// Shared types, codes and character helpers for the flat JSON object tokenizer.
`default_nettype none
package fjot_pkg;

   // Result kinds
   localparam logic [2:0] KIND_KEY  = 3'd0;
   localparam logic [2:0] KIND_STR  = 3'd1;
   localparam logic [2:0] KIND_NUM  = 3'd2;
   localparam logic [2:0] KIND_KEYE = 3'd3;
   localparam logic [2:0] KIND_VALE = 3'd4;
   localparam logic [2:0] KIND_DONE = 3'd5;
   localparam logic [2:0] KIND_ERR  = 3'd6;

   // Error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_EOT    = 2'd1;
   localparam logic [1:0] ERR_EXPECT = 2'd2;
   localparam logic [1:0] ERR_NONUM  = 2'd3;

   // Characters
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int MAX_RES         = 3;

   // One result
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [1:0] err;
   } res_type;

   // All results caused by one byte; slot 0 goes out first
   typedef struct packed {
      logic [1:0]                cnt;
      res_type [MAX_RES-1:0]     slot;
   } entry_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      return (c inside {[CH_ZERO:CH_NINE], CH_MINUS, CH_PLUS, CH_DOT, CH_LOW_E, CH_UP_E});
   endfunction

   // Append one result to an entry
   function automatic entry_type put_res(input entry_type e, input logic [2:0] k,
                                         input logic [7:0] b, input logic [1:0] er);
      entry_type r;
      r = e;
      r.slot[e.cnt] = '{kind: k, data: b, err: er};
      r.cnt = e.cnt + 2'd1;
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/fjot_front.sv]
// Front end: parser state machine that classifies each byte into a result entry.
`default_nettype none
module fjot_front import fjot_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      take,      // byte accepted this cycle
   input  wire logic [7:0] in_byte,
   input  wire logic      end_of_text,
   output entry_type      entry      // results for the current byte
);

   localparam logic [3:0] PH_OPEN    = 4'd0;
   localparam logic [3:0] PH_FIRST   = 4'd1;
   localparam logic [3:0] PH_KEY     = 4'd2;
   localparam logic [3:0] PH_COLON   = 4'd3;
   localparam logic [3:0] PH_VALUE   = 4'd4;
   localparam logic [3:0] PH_STR     = 4'd5;
   localparam logic [3:0] PH_NUM     = 4'd6;
   localparam logic [3:0] PH_AFTER   = 4'd7;
   localparam logic [3:0] PH_NEXTKEY = 4'd8;

   logic [3:0] phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic       done_ff, done_in;

   // Work out next state and the results of this byte
   always_comb begin
      logic [3:0] ph;
      logic       esc;
      logic       fin;
      logic [2:0] knd;
      entry_type  e;
      ph  = phase_ff;
      esc = esc_ff;
      fin = done_ff;
      e   = '0;
      knd = KIND_KEY;
      if (!done_ff) begin
         // close a number on its first non-number byte
         if (ph == PH_NUM && !is_num(in_byte)) begin
            e  = put_res(e, KIND_VALE, 8'd0, ERR_NONE);
            ph = PH_AFTER;
         end
         case (ph)
            PH_OPEN: begin
               if (!is_ws(in_byte)) begin
                  if (in_byte == CH_LBRACE) ph = PH_FIRST;
                  else begin
                     e   = put_res(e, KIND_ERR, CH_LBRACE, ERR_EXPECT);
                     fin = 1'b1;
                  end
               end
            end
            PH_FIRST: begin
               if (!is_ws(in_byte)) begin
                  if (in_byte == CH_RBRACE) begin
                     e   = put_res(e, KIND_DONE, 8'd0, ERR_NONE);
                     fin = 1'b1;
                  end else if (in_byte == CH_QUOTE) ph = PH_KEY;
                  else begin
                     e   = put_res(e, KIND_ERR, CH_QUOTE, ERR_EXPECT);
                     fin = 1'b1;
                  end
               end
            end
            PH_KEY, PH_STR: begin
               knd = (ph == PH_KEY) ? KIND_KEY : KIND_STR;
               if (esc) begin
                  // decode the escape, pass unknown ones through as written
                  esc = 1'b0;
                  if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
                     e = put_res(e, knd, in_byte, ERR_NONE);
                  end else if (in_byte == CH_LOW_N) begin
                     e = put_res(e, knd, CH_LF, ERR_NONE);
                  end else begin
                     e = put_res(e, knd, CH_BSLASH, ERR_NONE);
                     e = put_res(e, knd, in_byte, ERR_NONE);
                  end
               end else if (in_byte == CH_QUOTE) begin
                  if (ph == PH_KEY) begin
                     e  = put_res(e, KIND_KEYE, 8'd0, ERR_NONE);
                     ph = PH_COLON;
                  end else begin
                     e  = put_res(e, KIND_VALE, 8'd0, ERR_NONE);
                     ph = PH_AFTER;
                  end
               end else if (in_byte == CH_BSLASH) begin
                  esc = 1'b1;
               end else begin
                  e = put_res(e, knd, in_byte, ERR_NONE);
               end
            end
            PH_COLON: begin
               if (!is_ws(in_byte)) begin
                  if (in_byte == CH_COLON) ph = PH_VALUE;
                  else begin
                     e   = put_res(e, KIND_ERR, CH_COLON, ERR_EXPECT);
                     fin = 1'b1;
                  end
               end
            end
            PH_VALUE: begin
               if (!is_ws(in_byte)) begin
                  if (in_byte == CH_QUOTE) ph = PH_STR;
                  else if (is_num(in_byte)) begin
                     e  = put_res(e, KIND_NUM, in_byte, ERR_NONE);
                     ph = PH_NUM;
                  end else begin
                     e   = put_res(e, KIND_ERR, 8'd0, ERR_NONUM);
                     fin = 1'b1;
                  end
               end
            end
            PH_NUM: begin
               e = put_res(e, KIND_NUM, in_byte, ERR_NONE);
            end
            PH_AFTER: begin
               if (!is_ws(in_byte)) begin
                  if (in_byte == CH_COMMA) ph = PH_NEXTKEY;
                  else if (in_byte == CH_RBRACE) begin
                     e   = put_res(e, KIND_DONE, 8'd0, ERR_NONE);
                     fin = 1'b1;
                  end else begin
                     e   = put_res(e, KIND_ERR, CH_RBRACE, ERR_EXPECT);
                     fin = 1'b1;
                  end
               end
            end
            PH_NEXTKEY: begin
               if (!is_ws(in_byte)) begin
                  if (in_byte == CH_QUOTE) ph = PH_KEY;
                  else begin
                     e   = put_res(e, KIND_ERR, CH_QUOTE, ERR_EXPECT);
                     fin = 1'b1;
                  end
               end
            end
            default: ph = PH_OPEN;
         endcase

         // text ended inside the object: flush open number or escape, then fail
         if (end_of_text && !fin) begin
            if (ph == PH_NUM) e = put_res(e, KIND_VALE, 8'd0, ERR_NONE);
            if (esc) begin
               e = put_res(e, (ph == PH_KEY) ? KIND_KEY : KIND_STR, CH_BSLASH, ERR_NONE);
            end
            e   = put_res(e, KIND_ERR, 8'd0, ERR_EOT);
            fin = 1'b1;
         end
      end
      // rearm for the next text
      if (end_of_text) begin
         ph  = PH_OPEN;
         esc = 1'b0;
         fin = 1'b0;
      end
      phase_in = ph;
      esc_in   = esc;
      done_in  = fin;
      entry    = e;
   end

   // Advance the parser on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         esc_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

[rtl/fjot_queue.sv]
// Short queue of result entries between the front and back ends.
`default_nettype none
module fjot_queue import fjot_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  entry_type      push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output entry_type      head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type            store_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];

   // Step pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry; no reset for payload
   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

[rtl/fjot_back.sv]
// Back end: unpacks queued entries into single results on the output register.
`default_nettype none
module fjot_back import fjot_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  entry_type        head,
   output logic             pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_byte,
   output logic [1:0]       rsp_err,
   output logic             rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   res_type    res_ff, res_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   assign load   = head_valid && (!valid_ff || rsp_tready);
   assign at_end = (idx_ff == head.cnt - 2'd1);
   assign pop    = load && at_end;

   // Move the next slot into the output register, drop the entry after its last slot
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      res_in   = res_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = head.slot[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_kind   = res_ff.kind;
   assign rsp_byte   = res_ff.data;
   assign rsp_err    = res_ff.err;
   assign rsp_last   = last_ff;

endmodule
`default_nettype wire

[rtl/flat_json_object_tokenizer.sv]
// Top level of the flat JSON object tokenizer.
//
// Input channel req_*: one text byte per transaction, req_tlast on the final
// byte of a text. Result channel rsp_*: one token per transaction; tuser holds
// the token kind, tdata the content byte and error code, tlast marks the last
// token caused by one input byte. A byte that causes no token (whitespace,
// separators, bytes after done or error) produces no transaction.
// Throughput: one byte per cycle while each byte yields at most one token and
// the queue has room; a byte that yields two or three tokens sends them out in
// turn, the surplus absorbed by the entry queue between the parser and the
// output stage. Output rate is one token per cycle while the receiver is ready,
// set by the output register. The first token of a byte goes through the queue
// and the output register: the parser writes the queue when the byte is
// accepted, and the output stage then loads it from the queue head.
// Reset clears the parser to wait for an opening brace and empties the queue
// and output register. When the receiver stalls, the output holds its token,
// the queue fills, and req_tready falls once it is full.
`default_nettype none
module flat_json_object_tokenizer import fjot_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] token_byte, [9:8] error_code, rest 0
   output logic [2:0]       rsp_tuser,   // [2:0] token_kind
   output logic             rsp_tlast    // final_result
);

   logic      take;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   entry_type front_entry;
   entry_type q_head;
   logic [7:0] tok_byte;
   logic [1:0] tok_err;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   fjot_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_byte     (req_tdata),
      .end_of_text (req_tlast),
      .entry       (front_entry)
   );

   fjot_queue #(.Depth(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (take && (front_entry.cnt != 2'd0)),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   fjot_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_byte   (tok_byte),
      .rsp_err    (tok_err),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, tok_err, tok_byte};

endmodule
`default_nettype wire

[rtl/fjot_checker.sv]
// Port-level checker for the flat JSON object tokenizer, bound to the top level.
`default_nettype none
module fjot_checker import fjot_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // Hold a stalled token
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled token changed");

   // Output register is empty right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("token valid after reset");

   // Error tokens carry a code, all others none
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_ERR) == (rsp_tdata[9:8] != ERR_NONE)))
      else $error("error code does not match token kind");

   // Done and error end the tokens of their byte
   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_ERR) |-> rsp_tlast)
      else $error("done or error token not last of its byte");

endmodule

bind flat_json_object_tokenizer fjot_checker u_fjot_checker (.*);
`default_nettype wire
